// ===== src/kpi_pkg.sv =====
package kpi_pkg;

    localparam int TIME_W   = 32;
    localparam int COORD_W  = 32;
    localparam int COUNT_W  = 7;
    localparam int MAX_KEYS = 64;

    typedef enum logic [1:0] {
        FOUND_EXACT  = 2'd0,
        FOUND_INTERP = 2'd1,
        FOUND_LAST   = 2'd2,
        FOUND_EMPTY  = 2'd3
    } t_found;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic clear_idx;   // restart walk at entry zero
        logic step_idx;    // advance walk index
        logic rd_en;       // read entries idx and idx+1
        logic cmp_en;      // latch comparison of fetched pair
        logic div_start;   // load divider
        logic div_step;    // one quotient bit
        logic mul_en;      // multiply stage
        logic sel_a;       // result from entry a
        logic sel_zero;    // result zero
        logic out_en;      // present result
        t_found found;
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        logic is_last;
        logic eq_a;
        logic between;
        logic div_done;
    } t_stat;

endpackage

// ===== src/kpi_datapath.sv =====
module kpi_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr,
    input  logic [5:0]                i_key_index,
    input  logic [31:0]               i_key_time,
    input  logic signed [31:0]        i_key_x,
    input  logic signed [31:0]        i_key_y,
    input  logic signed [31:0]        i_key_z,
    input  logic                      i_load_q,
    input  logic [31:0]               i_query_time,
    input  logic [6:0]                i_count,
    input  kpi_pkg::t_ctrl            i_ctrl,
    output kpi_pkg::t_stat            o_stat,
    output logic                      o_valid,
    output logic signed [31:0]        o_pos_x,
    output logic signed [31:0]        o_pos_y,
    output logic signed [31:0]        o_pos_z,
    output logic [1:0]                o_how_found
);
    import kpi_pkg::*;

    localparam int IDX_W = $clog2(MAX_KEYS);
    localparam int NUM_W = TIME_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int FW    = FRAC_BITS + 1;

    logic [127:0] r_mem_lo [MAX_KEYS];
    logic [IDX_W:0] r_idx;
    logic [IDX_W:0] n_limit;
    logic [127:0] r_ea, r_eb;
    logic [TIME_W-1:0] r_t;
    logic [NUM_W-1:0] r_num;
    logic [TIME_W:0] r_rem;
    logic [TIME_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic r_eq, r_btw, r_last;
    logic signed [COORD_W:0] r_dx, r_dy, r_dz;
    logic signed [COORD_W+FW:0] r_px, r_py, r_pz;
    logic [TIME_W:0] n_rem_sh;
    logic [IDX_W-1:0] w_ra, w_rb;
    logic [IDX_W:0] w_idx1;

    // saturate count at table depth
    always_comb begin
        if (i_count > COUNT_W'(MAX_KEYS)) n_limit = (IDX_W+1)'(MAX_KEYS);
        else n_limit = (IDX_W+1)'(i_count);
    end

    assign w_idx1 = r_idx + 1'b1;
    assign w_ra   = r_idx[IDX_W-1:0];
    assign w_rb   = (w_idx1 >= (IDX_W+1)'(MAX_KEYS)) ? w_ra : w_idx1[IDX_W-1:0];

    logic [127:0] r_mem_hi [MAX_KEYS];

    always_ff @(posedge i_clk) begin
        if (i_wr && (7'(i_key_index) < 7'(MAX_KEYS))) begin
            r_mem_lo[i_key_index[IDX_W-1:0]] <= {i_key_time, i_key_x, i_key_y, i_key_z};
            r_mem_hi[i_key_index[IDX_W-1:0]] <= {i_key_time, i_key_x, i_key_y, i_key_z};
        end
        if (i_ctrl.rd_en) begin
            r_ea <= r_mem_lo[w_ra];
            r_eb <= r_mem_hi[w_rb];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_ctrl.clear_idx) begin
            r_idx <= '0;
        end else if (i_ctrl.step_idx) begin
            r_idx <= w_idx1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_q) r_t <= i_query_time;
        if (i_ctrl.cmp_en) begin
            r_eq   <= (r_ea[127:96] == r_t);
            r_btw  <= (r_ea[127:96] < r_t) && (r_eb[127:96] > r_t);
            r_last <= (w_idx1 == n_limit) || (n_limit == '0);
        end
    end

    assign o_stat.eq_a     = r_eq;
    assign o_stat.between  = r_btw;
    assign o_stat.is_last  = r_last;
    assign o_stat.div_done = (r_cnt == '0);

    // restoring divider, one quotient bit per cycle
    assign n_rem_sh = {r_rem[TIME_W-1:0], r_num[NUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctrl.div_start) begin
            r_num <= {r_t - r_ea[127:96], {FRAC_BITS{1'b0}}};
            r_den <= r_eb[127:96] - r_ea[127:96];
            r_rem <= '0;
            r_cnt <= CNT_W'(NUM_W);
        end else if (i_ctrl.div_step && r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
            if (n_rem_sh >= {1'b0, r_den}) begin
                r_rem <= n_rem_sh - {1'b0, r_den};
                r_num <= {r_num[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= n_rem_sh;
                r_num <= {r_num[NUM_W-2:0], 1'b0};
            end
        end
    end

    logic signed [FW-1:0] w_f;
    assign w_f = {1'b0, r_num[FRAC_BITS-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.div_start) begin
            r_dx <= $signed({r_eb[95], r_eb[95:64]}) - $signed({r_ea[95], r_ea[95:64]});
            r_dy <= $signed({r_eb[63], r_eb[63:32]}) - $signed({r_ea[63], r_ea[63:32]});
            r_dz <= $signed({r_eb[31], r_eb[31:0]}) - $signed({r_ea[31], r_ea[31:0]});
        end
        if (i_ctrl.mul_en) begin
            r_px <= r_dx * w_f;
            r_py <= r_dy * w_f;
            r_pz <= r_dz * w_f;
        end
    end

    logic signed [COORD_W+FW:0] w_sx, w_sy, w_sz;
    assign w_sx = r_px >>> FRAC_BITS;
    assign w_sy = r_py >>> FRAC_BITS;
    assign w_sz = r_pz >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_ctrl.out_en;
        end
        if (i_ctrl.out_en) begin
            o_how_found <= i_ctrl.found;
            if (i_ctrl.sel_zero) begin
                o_pos_x <= '0; o_pos_y <= '0; o_pos_z <= '0;
            end else if (i_ctrl.sel_a) begin
                o_pos_x <= r_ea[95:64]; o_pos_y <= r_ea[63:32]; o_pos_z <= r_ea[31:0];
            end else begin
                o_pos_x <= r_ea[95:64] + w_sx[COORD_W-1:0];
                o_pos_y <= r_ea[63:32] + w_sy[COORD_W-1:0];
                o_pos_z <= r_ea[31:0] + w_sz[COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rst_n && i_ctrl.step_idx)
            assert (r_idx < (IDX_W+1)'(MAX_KEYS))
                else $error("walk index past table");
    end
    property p_div_idle;
        @(posedge i_clk) disable iff (!i_rst_n) i_ctrl.div_start |=> r_cnt == CNT_W'(NUM_W);
    endproperty
    a_div_idle: assert property (p_div_idle) else $error("divider not loaded");
    a_out_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.out_en |=> o_valid) else $error("result strobe missing");
    a_step_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctrl.out_en && i_ctrl.step_idx)) else $error("step while presenting");

endmodule

// ===== src/kpi_ctrl.sv =====
module kpi_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_query,
    input  logic [6:0]     i_count,
    input  kpi_pkg::t_stat i_stat,
    output kpi_pkg::t_ctrl o_ctrl,
    output logic           o_busy
);
    import kpi_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_WAIT, S_CMP, S_DECIDE, S_DIV, S_MUL, S_ADD, S_DONE
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_ctrl  <= '0;
            o_busy  <= 1'b0;
        end else begin
            o_ctrl <= '0;
            case (r_state)
                S_IDLE: begin
                    if (i_query) begin
                        o_busy <= 1'b1;
                        if (i_count == '0) begin
                            o_ctrl.out_en   <= 1'b1;
                            o_ctrl.sel_zero <= 1'b1;
                            o_ctrl.found    <= FOUND_EMPTY;
                            r_state <= S_DONE;
                        end else begin
                            o_ctrl.clear_idx <= 1'b1;
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    o_ctrl.rd_en <= 1'b1;
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    o_ctrl.cmp_en <= 1'b1;
                    r_state <= S_CMP;
                end
                S_CMP: r_state <= S_DECIDE;
                S_DECIDE: begin
                    if (i_stat.eq_a || i_stat.is_last) begin
                        o_ctrl.out_en <= 1'b1;
                        o_ctrl.sel_a  <= 1'b1;
                        o_ctrl.found  <= i_stat.eq_a ? FOUND_EXACT : FOUND_LAST;
                        r_state <= S_DONE;
                    end else if (i_stat.between) begin
                        o_ctrl.div_start <= 1'b1;
                        r_state <= S_DIV;
                    end else begin
                        o_ctrl.step_idx <= 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_DIV: begin
                    if (i_stat.div_done && !o_ctrl.div_start) begin
                        o_ctrl.mul_en <= 1'b1;
                        r_state <= S_MUL;
                    end else begin
                        o_ctrl.div_step <= 1'b1;
                    end
                end
                S_MUL: r_state <= S_ADD;
                S_ADD: begin
                    o_ctrl.out_en <= 1'b1;
                    o_ctrl.found  <= FOUND_INTERP;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    o_busy  <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_busy_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_busy) else $error("busy while idle");
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> o_busy) else $error("done without request");
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_ctrl.div_start, o_ctrl.mul_en, o_ctrl.out_en}))
        else $error("overlapping commands");

endmodule

// ===== src/keyframe_position_interpolator.sv =====
// keyframe position interpolator: a start with i_command low writes one keyframe
// (slot, time, x/y/z) and gives no result. a start with i_command high queries
// i_query_time; busy holds until the one result is strobed on o_valid for
// exactly one cycle, and the receiver cannot stall it. the walk visits table
// entries in turn, each with a registered read of an entry and its neighbor,
// a compare stage and a decision; an interpolation then runs the bit-serial
// divider, a multiply and an add. an empty table answers without a walk.
// writes do not raise busy, so writes can be taken back to back.
// the keyframe count is taken from i_cfg_wdata by i_cfg_we and must only
// change while idle.
module keyframe_position_interpolator #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [6:0]         i_cfg_wdata,
    input  logic               start,
    output logic               busy,
    input  logic               i_command,
    input  logic [5:0]         i_key_index,
    input  logic [31:0]        i_key_time,
    input  logic signed [31:0] i_key_x,
    input  logic signed [31:0] i_key_y,
    input  logic signed [31:0] i_key_z,
    input  logic [31:0]        i_query_time,
    output logic               o_valid,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic [1:0]         o_how_found
);
    import kpi_pkg::*;

    logic [6:0] r_count;
    t_ctrl w_ctrl;
    t_stat w_stat;
    logic w_accept, w_busy;

    // request is taken when not busy
    assign w_accept = start && !busy;
    assign busy     = w_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    kpi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_query (w_accept && (i_command == CMD_QUERY)),
        .i_count (r_count),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl),
        .o_busy  (w_busy)
    );

    kpi_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (w_accept && (i_command == CMD_WRITE)),
        .i_key_index  (i_key_index),
        .i_key_time   (i_key_time),
        .i_key_x      (i_key_x),
        .i_key_y      (i_key_y),
        .i_key_z      (i_key_z),
        .i_load_q     (w_accept),
        .i_query_time (i_query_time),
        .i_count      (r_count),
        .i_ctrl       (w_ctrl),
        .o_stat       (w_stat),
        .o_valid      (o_valid),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y),
        .o_pos_z      (o_pos_z),
        .o_how_found  (o_how_found)
    );

endmodule
